/* rtl/core/feed_sequence_arbiter_assert.svh */
// Assertion macros used by the checker file.
`ifndef FEED_SEQUENCE_ARBITER_ASSERT_SVH
`define FEED_SEQUENCE_ARBITER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsa assertion failed");

// Next-cycle implication, disabled in reset.
`define FSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsa assertion failed");

`endif

/* rtl/core/fsa_pkg.sv */
package fsa_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int QDEPTH = 2;
  localparam int ADDR_W = 3;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_DEFS   = 2'd2;
  localparam logic [1:0] OP_SNAP   = 2'd3;

  localparam logic [2:0] ACT_LIVE = 3'd0;
  localparam logic [2:0] ACT_PFWD = 3'd1;
  localparam logic [2:0] ACT_PARK = 3'd2;
  localparam logic [2:0] ACT_DUP  = 3'd3;
  localparam logic [2:0] ACT_OVF  = 3'd4;
  localparam logic [2:0] ACT_REC  = 3'd5;

  localparam logic REC_DEFS = 1'b0;
  localparam logic REC_SNAP = 1'b1;

  localparam logic [ADDR_W-1:0] REG_GAP_LIMIT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_AGE_LIMIT = 3'd4;

  localparam logic [7:0]  GAP_LIMIT_RST = 8'd5;
  localparam logic [15:0] AGE_LIMIT_RST = 16'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] seq_num;
    logic [15:0] packet_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] out_seq;
    logic [15:0] out_tag;
    logic        recovery_kind;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  gap_limit;
    logic [15:0] age_limit;
  } cfg_t;

endpackage

/* rtl/core/fsa_front.sv */
module fsa_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  fsa_pkg::in_item_t in_item,
  output logic              q_valid,
  output fsa_pkg::in_item_t q_item,
  input  logic              q_pop
);

  localparam int PW = $clog2(fsa_pkg::QDEPTH);

  fsa_pkg::in_item_t mem [fsa_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_stall = (count == (PW+1)'(fsa_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

/* rtl/core/fsa_back.sv */
module fsa_back #(
  parameter int DEPTH = fsa_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  fsa_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  fsa_pkg::in_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output fsa_pkg::out_item_t out_item
);

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_DECIDE, S_FIN} state_t;

  state_t             state;
  fsa_pkg::in_item_t  cur;
  logic [31:0]        next_expected;
  logic [15:0]        tick_now;
  logic               defs_active;
  logic               snapshot_active;
  logic               defs_complete;
  logic [DEPTH-1:0]   slot_valid;
  logic [31:0]        slot_seq [DEPTH];
  logic [15:0]        slot_tag [DEPTH];
  logic [15:0]        slot_arrival [DEPTH];
  logic [IW-1:0]      idx;
  logic               found;
  logic [IW-1:0]      best_idx;
  logic [31:0]        best_seq;
  logic               pend_valid;
  fsa_pkg::out_item_t pend;

  logic               out_free;
  logic               can_emit;
  logic               emit_req;
  logic               emit_ok;
  fsa_pkg::out_item_t emit_item;
  logic               hit;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [31:0]        seq_dist;
  logic [2:0]         pkt_act;
  logic               park_we;
  logic [31:0]        gap;
  logic [15:0]        age;
  logic               trig;

  assign out_free = !out_valid || !out_stall;
  assign can_emit = !pend_valid || out_free;
  assign emit_ok  = !emit_req || can_emit;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign seq_dist = cur.seq_num - next_expected;
  assign gap      = best_seq - next_expected;
  assign age      = tick_now - slot_arrival[best_idx];
  assign trig     = (gap >= {24'd0, cfg.gap_limit}) || (age >= cfg.age_limit);

  // window lookup: duplicate hit and first free slot
  always_comb begin
    hit        = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_valid[i] && slot_seq[i] == cur.seq_num) hit = 1'b1;
      if (!slot_valid[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    if (cur.seq_num == next_expected) pkt_act = fsa_pkg::ACT_LIVE;
    else if (cur.seq_num < next_expected || hit) pkt_act = fsa_pkg::ACT_DUP;
    else if (seq_dist > 32'(DEPTH) || !free_found) pkt_act = fsa_pkg::ACT_OVF;
    else pkt_act = fsa_pkg::ACT_PARK;
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_item = '0;
    case (state)
      S_EXEC: begin
        if (cur.opcode == fsa_pkg::OP_PACKET) begin
          emit_req          = 1'b1;
          emit_item.action  = pkt_act;
          emit_item.out_seq = cur.seq_num;
          emit_item.out_tag = cur.packet_tag;
        end else if (cur.opcode == fsa_pkg::OP_DEFS && defs_active && !snapshot_active) begin
          emit_req                = 1'b1;
          emit_item.action        = fsa_pkg::ACT_REC;
          emit_item.out_seq       = next_expected;
          emit_item.recovery_kind = fsa_pkg::REC_SNAP;
        end
      end
      S_DECIDE: begin
        if (found && best_seq == next_expected) begin
          emit_req          = 1'b1;
          emit_item.action  = fsa_pkg::ACT_PFWD;
          emit_item.out_seq = best_seq;
          emit_item.out_tag = slot_tag[best_idx];
        end else if (found && best_seq > next_expected && trig
                     && !defs_active && !snapshot_active) begin
          emit_req                = 1'b1;
          emit_item.action        = fsa_pkg::ACT_REC;
          emit_item.out_seq       = next_expected;
          emit_item.recovery_kind = defs_complete ? fsa_pkg::REC_SNAP : fsa_pkg::REC_DEFS;
        end
      end
      default: ;
    endcase
  end

  assign park_we = (state == S_EXEC) && (cur.opcode == fsa_pkg::OP_PACKET)
                   && (pkt_act == fsa_pkg::ACT_PARK) && can_emit;

  always_ff @(posedge clk) begin
    if (park_we) begin
      slot_seq[free_idx]     <= cur.seq_num;
      slot_tag[free_idx]     <= cur.packet_tag;
      slot_arrival[free_idx] <= tick_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      next_expected   <= 32'd1;
      tick_now        <= '0;
      defs_active     <= 1'b0;
      snapshot_active <= 1'b0;
      defs_complete   <= 1'b0;
      slot_valid      <= '0;
      idx             <= '0;
      found           <= 1'b0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      // a new result pushes the held one out; last is set only in S_FIN
      if (emit_req && can_emit) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_item  <= pend;
        end
        pend       <= emit_item;
        pend_valid <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (emit_ok) begin
            idx   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
            case (cur.opcode)
              fsa_pkg::OP_PACKET: begin
                if (pkt_act == fsa_pkg::ACT_LIVE) next_expected <= next_expected + 32'd1;
                if (pkt_act == fsa_pkg::ACT_PARK) slot_valid[free_idx] <= 1'b1;
              end
              fsa_pkg::OP_TICK: tick_now <= tick_now + 16'd1;
              fsa_pkg::OP_DEFS: begin
                if (defs_active) begin
                  defs_active     <= 1'b0;
                  defs_complete   <= 1'b1;
                  snapshot_active <= 1'b1;
                end
              end
              default: begin
                if (snapshot_active) begin
                  snapshot_active <= 1'b0;
                  next_expected   <= cur.seq_num + 32'd1;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (slot_valid[idx] && (!found || slot_seq[idx] < best_seq)) begin
            found    <= 1'b1;
            best_idx <= idx;
            best_seq <= slot_seq[idx];
          end
          if (idx == IW'(DEPTH - 1)) state <= S_DECIDE;
          else idx <= idx + 1'b1;
        end
        S_DECIDE: begin
          if (!found) begin
            state <= S_FIN;
          end else if (best_seq < next_expected) begin
            slot_valid[best_idx] <= 1'b0;
            idx   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else if (best_seq == next_expected) begin
            if (can_emit) begin
              slot_valid[best_idx] <= 1'b0;
              next_expected <= next_expected + 32'd1;
              idx   <= '0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end else if (emit_ok) begin
            if (emit_req) begin
              if (defs_complete) snapshot_active <= 1'b1;
              else defs_active <= 1'b1;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid     <= 1'b1;
            out_item      <= pend;
            out_item.last <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/feed_sequence_arbiter.sv */
// Feed sequence arbiter: merges sequenced packets from redundant feeds into
// one gap-free stream of results. Each input item (packet, tick, definitions
// done, snapshot done) yields zero or more result items; the final one of an
// item carries last. Items queue in a two-entry front buffer, so the input
// side keeps moving while the back end works. The back end handles one item
// at a time: it classifies and executes the item, then runs one window scan
// over the DEPTH slots plus one decide step per drain pass, with one extra
// pass for every parked packet forwarded or discarded, and then closes out.
// The window scan over the DEPTH slot registers dominates the time per item.
// Output stalls hold the back end. Registers: gap_limit at 0x0, age_limit at
// 0x4 (APB).
module feed_sequence_arbiter #(
  parameter int DEPTH = fsa_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fsa_pkg::in_item_t           in_item,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output fsa_pkg::out_item_t          out_item,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  fsa_pkg::cfg_t     cfg;
  logic              q_valid;
  fsa_pkg::in_item_t q_item;
  logic              q_pop;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // config registers; writes to unmapped addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit <= fsa_pkg::GAP_LIMIT_RST;
      cfg.age_limit <= fsa_pkg::AGE_LIMIT_RST;
    end else if (cfg_we) begin
      case (paddr)
        fsa_pkg::REG_GAP_LIMIT: cfg.gap_limit <= pwdata[7:0];
        fsa_pkg::REG_AGE_LIMIT: cfg.age_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      fsa_pkg::REG_GAP_LIMIT: prdata = {24'd0, cfg.gap_limit};
      fsa_pkg::REG_AGE_LIMIT: prdata = {16'd0, cfg.age_limit};
      default:                prdata = '0;
    endcase
  end

  // front: input queue
  fsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: sequencing, reorder window, drain and recovery
  fsa_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/core/fsa_checker.sv */
`include "feed_sequence_arbiter_assert.svh"

module fsa_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input fsa_pkg::out_item_t out_item
);

  `FSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `FSA_ASSERT_NOW(a_action_range, out_valid, out_item.action <= fsa_pkg::ACT_REC)
  `FSA_ASSERT_NOW(a_kind_only_rec, out_valid && out_item.action != fsa_pkg::ACT_REC, !out_item.recovery_kind)
  `FSA_ASSERT_NOW(a_rec_no_tag, out_valid && out_item.action == fsa_pkg::ACT_REC, out_item.out_tag == 16'd0)

endmodule

bind feed_sequence_arbiter fsa_checker u_fsa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

// Testbench for feed_sequence_arbiter.
// A short directed table comes first. Then a random stream that follows the
// arbiter's own sequence state: mostly packets near the next expected
// number, ticks, and recovery-done events. Some noise is mixed in. An
// in-testbench model of the window predicts every result item. Result items
// are checked in order, field by field.
module tb;
  import fsa_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  // Worst back-end work per item is 17 drain passes, each a full window scan,
  // and two items can sit in the front buffer.
  localparam int SETTLE = 1200;
  localparam int WDOG_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  feed_sequence_arbiter #(.DEPTH(DEPTH)) u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
    .out_item, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Window model: arbiter state as the testbench sees it
  // ---------------------------------------------------------------------
  logic [7:0]  gap_lim;
  logic [15:0] age_lim;
  logic [31:0] next_seq;
  logic        park_vld [DEPTH];
  logic [31:0] park_seq [DEPTH];
  logic [15:0] park_tag [DEPTH];
  logic [15:0] park_time [DEPTH];
  logic [15:0] ticks;
  logic        defs_open, snap_open, defs_done;

  out_item_t   expected_results[$];
  logic [2:0]  first_action;
  int          result_cnt;
  int          errors = 0;
  bit          burst = 0;  // stretch with no idling on either side

  task automatic model_reset();
    gap_lim = GAP_LIMIT_RST;
    age_lim = AGE_LIMIT_RST;
    next_seq = 32'd1;
    for (int i = 0; i < DEPTH; i++) park_vld[i] = 1'b0;
    ticks = '0;
    defs_open = 1'b0;
    snap_open = 1'b0;
    defs_done = 1'b0;
  endtask

  function automatic out_item_t mk(logic [2:0] act, logic [31:0] s, logic [15:0] t,
                                   logic k);
    out_item_t r;
    r.action = act;
    r.out_seq = s;
    r.out_tag = t;
    r.recovery_kind = k;
    r.last = 1'b0;
    return r;
  endfunction

  // Applies one accepted item to the model and queues its result items.
  task automatic arbitrate(in_item_t it);
    out_item_t res[$];
    int free_idx, best;
    logic hit;
    logic [31:0] gap;
    logic [15:0] age;
    free_idx = -1;
    hit = 1'b0;
    case (it.opcode)
      OP_PACKET: begin
        if (it.seq_num == next_seq) begin
          res.push_back(mk(ACT_LIVE, it.seq_num, it.packet_tag, REC_DEFS));
          next_seq = next_seq + 1;
        end else if (it.seq_num < next_seq) begin
          res.push_back(mk(ACT_DUP, it.seq_num, it.packet_tag, REC_DEFS));
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (park_vld[i] && park_seq[i] == it.seq_num) hit = 1'b1;
            if (!park_vld[i] && free_idx < 0) free_idx = i;
          end
          if (hit) begin
            // already parked
            res.push_back(mk(ACT_DUP, it.seq_num, it.packet_tag, REC_DEFS));
          end else if (it.seq_num - next_seq > DEPTH || free_idx < 0) begin
            res.push_back(mk(ACT_OVF, it.seq_num, it.packet_tag, REC_DEFS));
          end else begin
            park_vld[free_idx] = 1'b1;
            park_seq[free_idx] = it.seq_num;
            park_tag[free_idx] = it.packet_tag;
            park_time[free_idx] = ticks;
            res.push_back(mk(ACT_PARK, it.seq_num, it.packet_tag, REC_DEFS));
          end
        end
      end
      OP_TICK: ticks = ticks + 16'd1;
      OP_DEFS: begin
        if (defs_open) begin
          defs_open = 1'b0;
          defs_done = 1'b1;
          if (!snap_open) begin
            snap_open = 1'b1;
            res.push_back(mk(ACT_REC, next_seq, '0, REC_SNAP));
          end
        end
      end
      default: begin
        if (snap_open) begin
          snap_open = 1'b0;
          next_seq = it.seq_num + 1;
        end
      end
    endcase
    // drain: release in-order parked items, drop stale ones, then loss check
    for (int n = 0; n <= DEPTH; n++) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++)
        if (park_vld[i] && (best < 0 || park_seq[i] < park_seq[best])) best = i;
      if (best < 0) break;
      if (park_seq[best] < next_seq) begin
        park_vld[best] = 1'b0;
      end else if (park_seq[best] == next_seq) begin
        res.push_back(mk(ACT_PFWD, park_seq[best], park_tag[best], REC_DEFS));
        next_seq = next_seq + 1;
        park_vld[best] = 1'b0;
      end else begin
        gap = park_seq[best] - next_seq;
        age = ticks - park_time[best];
        if ((gap >= gap_lim || age >= age_lim) && !defs_open && !snap_open) begin
          if (defs_done) begin
            snap_open = 1'b1;
            res.push_back(mk(ACT_REC, next_seq, '0, REC_SNAP));
          end else begin
            defs_open = 1'b1;
            res.push_back(mk(ACT_REC, next_seq, '0, REC_DEFS));
          end
        end
        break;
      end
    end
    result_cnt = res.size();
    if (result_cnt > 0) begin
      res[result_cnt-1].last = 1'b1;
      first_action = res[0].action;
    end
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // ---------------------------------------------------------------------
  // Drivers. Handshakes are decided at the falling edge, where every
  // signal is stable, and take effect at the next rising edge.
  // ---------------------------------------------------------------------
  task automatic send(in_item_t it);
    if (!burst)
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (in_stall);
    arbitrate(it);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == REG_GAP_LIMIT) gap_lim = d[7:0];
    else age_lim = d[15:0];
    @(posedge clk);
  endtask

  // Wait until every result item has arrived and the back end has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk)
    out_stall <= burst ? 1'b0 : ($urandom_range(99) < 34);

  // Result checker
  always @(negedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.action !== exp_r.action || out_item.out_seq !== exp_r.out_seq ||
            out_item.out_tag !== exp_r.out_tag ||
            out_item.recovery_kind !== exp_r.recovery_kind ||
            out_item.last !== exp_r.last) begin
          $display("%0t: mismatch expected act=%0d seq=%h tag=%h kind=%0d last=%0d",
                   $time, exp_r.action, exp_r.out_seq, exp_r.out_tag,
                   exp_r.recovery_kind, exp_r.last);
          $display("%0t:          actual   act=%0d seq=%h tag=%h kind=%0d last=%0d",
                   $time, out_item.action, out_item.out_seq, out_item.out_tag,
                   out_item.recovery_kind, out_item.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with nothing accepted on either channel
  int quiet_cycles = 0;
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed table. A typed action is the first result of that row.
  // ---------------------------------------------------------------------
  typedef struct {
    logic [1:0]  op;
    logic [31:0] s;
    logic [15:0] t;
    bit          typed;
    logic [2:0]  act;
  } row_t;

  row_t dir_rows[] = '{
    '{OP_PACKET, 32'd1,          16'hFFFF, 1, ACT_LIVE},  // in order after reset
    '{OP_PACKET, 32'd0,          16'h0000, 1, ACT_DUP},   // below next
    '{OP_PACKET, 32'd3,          16'h1234, 1, ACT_PARK},
    '{OP_PACKET, 32'd3,          16'h4321, 1, ACT_DUP},   // already parked
    '{OP_PACKET, 32'd2,          16'hAAAA, 1, ACT_LIVE},  // releases 3
    '{OP_PACKET, 32'hFFFF_FFFF,  16'h5555, 1, ACT_OVF},   // beyond window
    '{OP_PACKET, 32'd21,         16'h0001, 1, ACT_OVF},   // just past edge
    '{OP_PACKET, 32'd20,         16'h0002, 1, ACT_PARK},  // window edge, gap
    '{OP_TICK,   32'd0,          16'h0,    0, ACT_LIVE},
    '{OP_SNAP,   32'd7,          16'h0,    0, ACT_LIVE},  // ignored, no snapshot
    '{OP_DEFS,   32'd0,          16'h0,    0, ACT_LIVE},  // starts snapshot
    '{OP_DEFS,   32'd0,          16'h0,    0, ACT_LIVE},  // ignored now
    '{OP_PACKET, 32'd6,          16'h0003, 0, ACT_LIVE},
    '{OP_SNAP,   32'hFFFF_FFFE,  16'h0,    0, ACT_LIVE},  // stale drop, wrap next
    '{OP_PACKET, 32'hFFFF_FFFF,  16'h0004, 1, ACT_LIVE},
    '{OP_PACKET, 32'd2,          16'h0005, 1, ACT_PARK},  // after wrap to 0
    '{OP_PACKET, 32'd0,          16'h0006, 1, ACT_LIVE},
    '{OP_PACKET, 32'd1,          16'h0007, 1, ACT_LIVE},
    '{OP_TICK,   32'hFFFF_FFFF,  16'hFFFF, 0, ACT_LIVE},
    '{OP_PACKET, 32'd9,          16'h0008, 0, ACT_LIVE}
  };

  // Random item that mostly follows the arbiter's sequence
  function automatic in_item_t pick_item();
    in_item_t it;
    int r;
    r = $urandom_range(99);
    it.packet_tag = 16'($urandom);
    it.seq_num = $urandom;
    if (r < 62) begin
      it.opcode = OP_PACKET;
      it.seq_num = next_seq + $urandom_range(DEPTH + 3) - 2;
    end else if (r < 67) begin
      it.opcode = OP_PACKET;  // far off
    end else if (r < 82) begin
      it.opcode = OP_TICK;
    end else if (r < 91) begin
      it.opcode = OP_DEFS;
    end else begin
      it.opcode = OP_SNAP;
      if ($urandom_range(3) == 0) it.seq_num = 32'hFFFF_FFF0 + $urandom_range(15);
      else if ($urandom_range(3) != 0) it.seq_num = next_seq + $urandom_range(6) - 1;
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    model_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.opcode = dir_rows[i].op;
      it.seq_num = dir_rows[i].s;
      it.packet_tag = dir_rows[i].t;
      send(it);
      if (dir_rows[i].typed && (result_cnt == 0 || first_action != dir_rows[i].act)) begin
        $display("%0t: row %0d expected action %0d, actual %0d", $time, i,
                 dir_rows[i].act, first_action);
        errors++;
      end
    end
    settle();

    // Four settings: tightest, loosest, reset-like, and random
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin reg_write(REG_GAP_LIMIT, 32'd1);   reg_write(REG_AGE_LIMIT, 32'd0); end
        1: begin reg_write(REG_GAP_LIMIT, 32'd255); reg_write(REG_AGE_LIMIT, 32'hFFFF); end
        2: begin reg_write(REG_GAP_LIMIT, 32'd5);   reg_write(REG_AGE_LIMIT, 32'd5); end
        default: begin
          reg_write(REG_GAP_LIMIT, $urandom_range(255, 1));
          reg_write(REG_AGE_LIMIT, $urandom_range(40));
        end
      endcase
      burst = (ph == 2);
      for (int n = 0; n < 110; n++) send(pick_item());
      settle();
      burst = 0;
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* feed_sequence_arbiter.f */
+incdir+rtl/core
rtl/core/fsa_pkg.sv
rtl/core/fsa_front.sv
rtl/core/fsa_back.sv
rtl/core/feed_sequence_arbiter.sv
rtl/core/fsa_checker.sv
sim/tb.sv
